[hw/rtl/trbi_pkg.sv]
// trbi_pkg: shared widths, payload structs and saturation helpers for the
// triangle rest basis inverse block. No dependencies.
package trbi_pkg;

  localparam int COORD_WIDTH   = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int AREA_WIDTH    = 48;
  // partial product steps of the pipelined wide multipliers
  localparam int MUL_STEPS     = 9;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] v0_x;
    logic signed [COORD_WIDTH-1:0] v0_y;
    logic signed [COORD_WIDTH-1:0] v0_z;
    logic signed [COORD_WIDTH-1:0] v1_x;
    logic signed [COORD_WIDTH-1:0] v1_y;
    logic signed [COORD_WIDTH-1:0] v1_z;
    logic signed [COORD_WIDTH-1:0] v2_x;
    logic signed [COORD_WIDTH-1:0] v2_y;
    logic signed [COORD_WIDTH-1:0] v2_z;
  } tri_in_t;

  typedef struct packed {
    logic [AREA_WIDTH-1:0]         area;
    logic signed [COORD_WIDTH-1:0] inv_00;
    logic signed [COORD_WIDTH-1:0] inv_01;
    logic signed [COORD_WIDTH-1:0] inv_10;
    logic signed [COORD_WIDTH-1:0] inv_11;
    logic                          degenerate;
  } tri_res_t;

  // clip a magnitude to the largest positive field value
  function automatic logic [COORD_WIDTH-1:0] sat_pos(input logic [COORD_WIDTH-1:0] q);
    logic [COORD_WIDTH-1:0] cap;
    cap = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    return (q > cap) ? cap : q;
  endfunction

  // clip a magnitude to the most negative field value and negate
  function automatic logic [COORD_WIDTH-1:0] sat_neg(input logic [COORD_WIDTH-1:0] q);
    logic [COORD_WIDTH-1:0] cap;
    logic [COORD_WIDTH-1:0] mag;
    cap = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    mag = (q > cap) ? cap : q;
    return (~mag) + COORD_WIDTH'(1);
  endfunction

endpackage

[hw/rtl/trbi_mul.sv]
// trbi_mul: pipelined unsigned multiplier, several lanes in lockstep, one
// digit of b per stage, with a sideband bus that travels alongside.
// Depends on nothing but its parameters.
module trbi_mul #(
  parameter int NL    = 1,
  parameter int WA    = 32,
  parameter int WB    = 32,
  parameter int STEPS = 4,
  parameter int WS    = 1
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic [NL-1:0][WA-1:0]      a,
  input  logic [NL-1:0][WB-1:0]      b,
  input  logic [WS-1:0]              side_i,
  output logic [NL-1:0][WA+WB-1:0]   p,
  output logic [WS-1:0]              side_o
);

  localparam int DW  = (WB + STEPS - 1) / STEPS;
  localparam int WBP = DW * STEPS;
  localparam int WP  = WA + WBP;

  logic [NL-1:0][WA-1:0]  a_r   [STEPS];
  logic [NL-1:0][WBP-1:0] b_r   [STEPS];
  logic [NL-1:0][WP-1:0]  acc_r [STEPS];
  logic [WS-1:0]          s_r   [STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_stg
    logic [NL-1:0][WA-1:0]    a_src;
    logic [NL-1:0][WBP-1:0]   b_src;
    logic [NL-1:0][WP-1:0]    acc_src;
    logic [WS-1:0]            s_src;
    logic [NL-1:0][WA+DW-1:0] pr;

    // stage operands: inputs for the first step, previous stage otherwise
    if (k == 0) begin : g_first
      always_comb begin
        for (int l = 0; l < NL; l++) begin
          a_src[l]   = a[l];
          b_src[l]   = WBP'(b[l]);
          acc_src[l] = '0;
        end
        s_src = side_i;
      end
    end else begin : g_next
      assign a_src   = a_r[k-1];
      assign b_src   = b_r[k-1];
      assign acc_src = acc_r[k-1];
      assign s_src   = s_r[k-1];
    end

    // one digit partial product per lane
    always_comb begin
      for (int l = 0; l < NL; l++) begin
        pr[l] = a_src[l] * b_src[l][k*DW +: DW];
      end
    end

    // accumulate shifted partial product
    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < NL; l++) begin
          a_r[k][l]   <= a_src[l];
          b_r[k][l]   <= b_src[l];
          acc_r[k][l] <= acc_src[l] + (WP'(pr[l]) << (k*DW));
        end
        s_r[k] <= s_src;
      end
    end
  end

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      p[l] = acc_r[STEPS-1][l][WA+WB-1:0];
    end
  end
  assign side_o = s_r[STEPS-1];

endmodule

[hw/rtl/trbi_solve.sv]
// trbi_solve: pipelined search for the largest q below 2^QB with
// q*q*d <= m, one bit of q per stage, then hold stages up to LAT.
// Depends on nothing but its parameters.
module trbi_solve #(
  parameter int WD  = 8,
  parameter int WM  = 16,
  parameter int QB  = 8,
  parameter int LAT = 8
) (
  input  logic          clk,
  input  logic          en,
  input  logic [WD-1:0] d_i,
  input  logic [WM-1:0] m_i,
  output logic [QB-1:0] q
);

  localparam int WQD = WD + QB;
  localparam int WT  = WD + 2*QB + 1;
  localparam int WC  = ((WT > WM) ? WT : WM) + 1;

  logic [WM-1:0]  r_r  [LAT];
  logic [WQD-1:0] qd_r [LAT];
  logic [QB-1:0]  q_r  [LAT];
  logic [WD-1:0]  d_r  [LAT];

  for (genvar k = 0; k < LAT; k++) begin : g_stg
    logic [WM-1:0]  r_src;
    logic [WQD-1:0] qd_src;
    logic [QB-1:0]  q_src;
    logic [WD-1:0]  d_src;

    if (k == 0) begin : g_first
      assign r_src  = m_i;
      assign qd_src = '0;
      assign q_src  = '0;
      assign d_src  = d_i;
    end else begin : g_next
      assign r_src  = r_r[k-1];
      assign qd_src = qd_r[k-1];
      assign q_src  = q_r[k-1];
      assign d_src  = d_r[k-1];
    end

    if (k < QB) begin : g_bit
      localparam int B = QB - 1 - k;
      logic [WC-1:0] t;
      logic [WC-1:0] diff;

      // growth of q*q*d when bit B is set: 2^(B+1)*q*d + 2^(2B)*d
      assign t    = (WC'(qd_src) << (B+1)) + (WC'(d_src) << (2*B));
      assign diff = WC'(r_src) - t;

      always_ff @(posedge clk) begin
        if (en) begin
          d_r[k] <= d_src;
          if (!diff[WC-1]) begin
            r_r[k]  <= diff[WM-1:0];
            qd_r[k] <= qd_src + (WQD'(d_src) << B);
            q_r[k]  <= q_src | (QB'(1) << B);
          end else begin
            r_r[k]  <= r_src;
            qd_r[k] <= qd_src;
            q_r[k]  <= q_src;
          end
        end
      end
    end else begin : g_hold
      // align latency with the longest search
      always_ff @(posedge clk) begin
        if (en) begin
          r_r[k]  <= r_src;
          qd_r[k] <= qd_src;
          q_r[k]  <= q_src;
          d_r[k]  <= d_src;
        end
      end
    end
  end

  assign q = q_r[LAT-1];

endmodule

[hw/rtl/triangle_rest_basis_inverse.sv]
// triangle_rest_basis_inverse: top level of the rest basis inverse pipeline.
// Uses trbi_pkg, trbi_mul and trbi_solve.
//
// One triangle (three Q16.16 vertices) enters on the tri channel, one result
// (area, 2x2 inverse rest edge matrix, degenerate flag) leaves on res.
// A transaction happens at a clock edge with valid high and stall low.
// Throughput is one triangle per cycle while res is not stalled: stages
// hold edges, cross products, sums, magnitudes, a pipelined squaring unit,
// the normal length sum, a pipelined wide product and a bit-per-stage
// root/quotient search (48 stages for the area).
// All stages advance together; when res is stalled with a result waiting,
// the whole pipeline holds and tri_stall is raised in the same cycle, so
// nothing is lost or repeated. Empty slots do not hold the pipeline.
// Synchronous reset empties the pipeline (all valid bits cleared); the
// block is ready in the first cycle after reset.
module triangle_rest_basis_inverse
  import trbi_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     tri_valid,
  output logic     tri_stall,
  input  tri_in_t  tri_data,
  output logic     res_valid,
  input  logic     res_stall,
  output tri_res_t res_data
);

  localparam int C     = COORD_WIDTH;
  localparam int E     = C + 1;
  localparam int WN    = 2*E + 1;
  localparam int WS1   = 2*E + 2;
  localparam int WDT   = 2*E + 2;
  localparam int WM00  = 2*E + 3;
  localparam int SQW   = WM00;
  localparam int SQL   = 5;
  localparam int WNN   = 2*WN + 2;
  localparam int WDD   = WNN + WS1;
  localparam int LAT   = (AREA_WIDTH > C) ? AREA_WIDTH : C;
  localparam int NSTG  = 4 + MUL_STEPS + 1 + MUL_STEPS + LAT + 1;
  localparam int WSQS  = WS1 + 3;
  localparam int WDS   = WNN + 2*WM00 + 2*WDT + WS1 + 3;
  localparam int ASH   = 2*FRAC_BITS + 2;
  localparam int WMA   = WNN - ASH;
  localparam int WMX   = 4*FRAC_BITS + 1;
  localparam int WM0   = 2*WM00 + 4*FRAC_BITS;
  localparam int WM1   = 2*WDT + 4*FRAC_BITS;
  localparam logic [WMX-1:0] M_UNIT = WMX'(1) << (4*FRAC_BITS);

  logic            adv;
  logic [NSTG-1:0] vld;

  // shared advance: hold only when a finished result is refused
  assign adv       = !res_valid || !res_stall;
  assign tri_stall = !adv;
  assign res_valid = vld[NSTG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NSTG-2:0], tri_valid};
    end
  end

  // edges relative to vertex zero
  logic signed [E-1:0] e1 [3];
  logic signed [E-1:0] e2 [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      e1[0] <= E'(tri_data.v1_x) - E'(tri_data.v0_x);
      e1[1] <= E'(tri_data.v1_y) - E'(tri_data.v0_y);
      e1[2] <= E'(tri_data.v1_z) - E'(tri_data.v0_z);
      e2[0] <= E'(tri_data.v2_x) - E'(tri_data.v0_x);
      e2[1] <= E'(tri_data.v2_y) - E'(tri_data.v0_y);
      e2[2] <= E'(tri_data.v2_z) - E'(tri_data.v0_z);
    end
  end

  // cross, square and dot products of edge components
  logic signed [2*E-1:0] pt [3];
  logic signed [2*E-1:0] pu [3];
  logic signed [2*E-1:0] psq [3];
  logic signed [2*E-1:0] pdt [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      pt[0] <= e1[1] * e2[2];
      pu[0] <= e1[2] * e2[1];
      pt[1] <= e1[2] * e2[0];
      pu[1] <= e1[0] * e2[2];
      pt[2] <= e1[0] * e2[1];
      pu[2] <= e1[1] * e2[0];
      for (int k = 0; k < 3; k++) begin
        psq[k] <= e1[k] * e1[k];
        pdt[k] <= e1[k] * e2[k];
      end
    end
  end

  // normal components, squared edge length, edge dot product
  logic signed [WN-1:0]  nrm [3];
  logic [WS1-1:0]        s1_3;
  logic signed [WDT-1:0] dot_3;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        nrm[k] <= WN'(pt[k]) - WN'(pu[k]);
      end
      s1_3  <= WS1'(psq[0]) + WS1'(psq[1]) + WS1'(psq[2]);
      dot_3 <= WDT'(pdt[0]) + WDT'(pdt[1]) + WDT'(pdt[2]);
    end
  end

  // magnitudes and signs of the numerators
  logic signed [WM00-1:0] m00_c;
  logic [WN-1:0]          nmag [3];
  logic [WM00-1:0]        mag00;
  logic [WDT-1:0]         dmag;
  logic [WS1-1:0]         s1_4;
  logic                   neg00_4;
  logic                   neg10_4;
  logic                   degen_4;

  assign m00_c = WM00'(dot_3) - $signed(WM00'(s1_3));

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        nmag[k] <= nrm[k][WN-1] ? WN'(-nrm[k]) : WN'(nrm[k]);
      end
      mag00   <= m00_c[WM00-1] ? WM00'(-m00_c) : WM00'(m00_c);
      dmag    <= dot_3[WDT-1] ? WDT'(-dot_3) : WDT'(dot_3);
      neg00_4 <= m00_c[WM00-1];
      neg10_4 <= !dot_3[WDT-1] && (dot_3 != '0);
      degen_4 <= (nrm[0] == '0) && (nrm[1] == '0) && (nrm[2] == '0);
      s1_4    <= s1_3;
    end
  end

  // five squares in one lane-parallel multiplier
  logic [SQL-1:0][SQW-1:0]   sq_in;
  logic [SQL-1:0][2*SQW-1:0] sq_out;
  logic [WSQS-1:0]           sq_side;

  assign sq_in[0] = SQW'(nmag[0]);
  assign sq_in[1] = SQW'(nmag[1]);
  assign sq_in[2] = SQW'(nmag[2]);
  assign sq_in[3] = mag00;
  assign sq_in[4] = SQW'(dmag);

  trbi_mul #(
    .NL(SQL), .WA(SQW), .WB(SQW), .STEPS(MUL_STEPS), .WS(WSQS)
  ) u_sq (
    .clk    (clk),
    .en     (adv),
    .a      (sq_in),
    .b      (sq_in),
    .side_i ({s1_4, neg00_4, neg10_4, degen_4}),
    .p      (sq_out),
    .side_o (sq_side)
  );

  // squared normal length
  logic [WNN-1:0]    nsum;
  logic [2*WM00-1:0] m00sq;
  logic [2*WDT-1:0]  dsq;
  logic [WSQS-1:0]   side_n;

  always_ff @(posedge clk) begin
    if (adv) begin
      nsum   <= WNN'(sq_out[0][2*WN-1:0]) + WNN'(sq_out[1][2*WN-1:0])
              + WNN'(sq_out[2][2*WN-1:0]);
      m00sq  <= sq_out[3];
      dsq    <= sq_out[4][2*WDT-1:0];
      side_n <= sq_side;
    end
  end

  // divisor square for the column zero entries: |e1|^2 * |n|^2
  logic [0:0][WDD-1:0] dd_out;
  logic [WDS-1:0]      dd_side;
  logic [WNN-1:0]      nsum_d;
  logic [2*WM00-1:0]   m00sq_d;
  logic [2*WDT-1:0]    dsq_d;
  logic [WS1-1:0]      s1_d;
  logic [2:0]          flg_d;

  trbi_mul #(
    .NL(1), .WA(WNN), .WB(WS1), .STEPS(MUL_STEPS), .WS(WDS)
  ) u_dd (
    .clk    (clk),
    .en     (adv),
    .a      (nsum),
    .b      (side_n[WSQS-1:3]),
    .side_i ({nsum, m00sq, dsq, side_n}),
    .p      (dd_out),
    .side_o (dd_side)
  );

  assign {nsum_d, m00sq_d, dsq_d, s1_d, flg_d} = dd_side;

  // root and quotient searches
  logic [AREA_WIDTH-1:0] q_area;
  logic [C-1:0]          q_x1;
  logic [C-1:0]          q_00;
  logic [C-1:0]          q_10;

  trbi_solve #(.WD(1), .WM(WMA), .QB(AREA_WIDTH), .LAT(LAT)) u_area (
    .clk (clk), .en (adv), .d_i (1'b1), .m_i (nsum_d[WNN-1:ASH]), .q (q_area)
  );

  trbi_solve #(.WD(WS1), .WM(WMX), .QB(C), .LAT(LAT)) u_x1 (
    .clk (clk), .en (adv), .d_i (s1_d), .m_i (M_UNIT), .q (q_x1)
  );

  trbi_solve #(.WD(WDD), .WM(WM0), .QB(C), .LAT(LAT)) u_00 (
    .clk (clk), .en (adv), .d_i (dd_out[0]),
    .m_i ({m00sq_d, {(4*FRAC_BITS){1'b0}}}), .q (q_00)
  );

  trbi_solve #(.WD(WDD), .WM(WM1), .QB(C), .LAT(LAT)) u_10 (
    .clk (clk), .en (adv), .d_i (dd_out[0]),
    .m_i ({dsq_d, {(4*FRAC_BITS){1'b0}}}), .q (q_10)
  );

  // sign and degenerate flags ride alongside the searches
  logic [2:0] flg_pipe [LAT];

  always_ff @(posedge clk) begin
    if (adv) begin
      flg_pipe[0] <= flg_d;
      for (int i = 1; i < LAT; i++) begin
        flg_pipe[i] <= flg_pipe[i-1];
      end
    end
  end

  // saturate, apply signs, zero degenerate results
  logic neg00_o;
  logic neg10_o;
  logic degen_o;

  assign {neg00_o, neg10_o, degen_o} = flg_pipe[LAT-1];

  always_ff @(posedge clk) begin
    if (adv) begin
      res_data.degenerate <= degen_o;
      if (degen_o) begin
        res_data.area   <= '0;
        res_data.inv_00 <= '0;
        res_data.inv_01 <= '0;
        res_data.inv_10 <= '0;
        res_data.inv_11 <= '0;
      end else begin
        res_data.area   <= q_area;
        res_data.inv_00 <= neg00_o ? sat_neg(q_00) : sat_pos(q_00);
        res_data.inv_01 <= sat_neg(q_x1);
        res_data.inv_10 <= neg10_o ? sat_neg(q_10) : sat_pos(q_10);
        res_data.inv_11 <= sat_pos(q_x1);
      end
    end
  end

endmodule

[hw/rtl/trbi_check.sv]
// trbi_check: port-level checks for triangle_rest_basis_inverse, bound to
// the top level. Depends on trbi_pkg.
module trbi_check
  import trbi_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     tri_valid,
  input logic     tri_stall,
  input logic     res_valid,
  input logic     res_stall,
  input tri_res_t res_data
);

  // input stalls exactly when a waiting result is refused
  a_stall_link: assert property (@(posedge clk) disable iff (rst)
    tri_stall == (res_valid && res_stall))
    else $error("tri_stall does not follow the result stall");

  // pipeline comes out of reset empty
  a_reset_empty: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !res_valid)
    else $error("result valid right after reset");

  // refused result transaction holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res_data))
    else $error("stalled result changed");

  // column one entries are negatives of each other unless clipped
  a_col_one: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_data.degenerate |->
      (res_data.inv_01 == -res_data.inv_11) ||
      (res_data.inv_11 == {1'b0, {(COORD_WIDTH-1){1'b1}}} &&
       res_data.inv_01 == {1'b1, {(COORD_WIDTH-1){1'b0}}}))
    else $error("inv_01 and inv_11 disagree");

  // degenerate results have zero area, inv_00 and inv_10
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_data.degenerate |->
      res_data.area == '0 && res_data.inv_00 == '0 && res_data.inv_10 == '0)
    else $error("degenerate result not cleared");

endmodule

bind triangle_rest_basis_inverse trbi_check u_check (.*);

[tb/sv/tb_triangle_rest_basis_inverse.sv]
// tb_triangle_rest_basis_inverse: self-checking testbench for the triangle rest basis
// inverse pipeline. Depends on trbi_pkg and triangle_rest_basis_inverse.
module tb_triangle_rest_basis_inverse;
  import trbi_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [319:0] wide_t;

  // holds expected results and compares accepted ones against them
  class area_inverse_board;
    tri_res_t expected_q[$];
    int       mismatches;

    // largest q below 2^nbits with q*q*den <= num
    static function automatic logic [63:0] root_search(wide_t den, wide_t num, int nbits);
      logic [63:0] q;
      logic [63:0] cand;
      wide_t       trial;
      q = '0;
      for (int b = nbits - 1; b >= 0; b--) begin
        cand  = q | (64'd1 << b);
        trial = $signed({256'd0, cand});
        if (trial * trial * den <= num) q = cand;
      end
      return q;
    endfunction

    // trunc(m * 2^32 / sqrt(den)) in Q16.16, saturated
    static function automatic logic [31:0] scaled_ratio(wide_t m, wide_t den);
      wide_t       num;
      logic [63:0] q;
      num = m * m * (wide_t'(1) <<< 64);
      if (m < 0) begin
        q = root_search(den, num, 32);
        if (q > 64'h8000_0000) q = 64'h8000_0000;
        return 32'(-q);
      end
      q = root_search(den, num, 31);
      return q[31:0];
    endfunction

    static function automatic tri_res_t predict_result(tri_in_t t);
      wide_t    p0[3], p1[3], p2[3], e1[3], e2[3], n[3];
      wide_t    nsq, s1, dot12;
      tri_res_t r;
      p0 = '{$signed(t.v0_x), $signed(t.v0_y), $signed(t.v0_z)};
      p1 = '{$signed(t.v1_x), $signed(t.v1_y), $signed(t.v1_z)};
      p2 = '{$signed(t.v2_x), $signed(t.v2_y), $signed(t.v2_z)};
      for (int k = 0; k < 3; k++) begin
        e1[k] = p1[k] - p0[k];
        e2[k] = p2[k] - p0[k];
      end
      for (int k = 0; k < 3; k++)
        n[k] = e1[(k + 1) % 3] * e2[(k + 2) % 3] - e1[(k + 2) % 3] * e2[(k + 1) % 3];
      nsq = 0; s1 = 0; dot12 = 0;
      for (int k = 0; k < 3; k++) begin
        nsq   = nsq + n[k] * n[k];
        s1    = s1 + e1[k] * e1[k];
        dot12 = dot12 + e1[k] * e2[k];
      end
      r = '0;
      // zero normal covers zero first edge and collinear vertices
      if (nsq == 0) begin
        r.degenerate = 1'b1;
        return r;
      end
      r.area   = 48'(root_search(wide_t'(1) <<< 34, nsq, 48));
      r.inv_00 = scaled_ratio(dot12 - s1, s1 * nsq);
      r.inv_01 = scaled_ratio(-1, s1);
      r.inv_10 = scaled_ratio(-dot12, s1 * nsq);
      r.inv_11 = scaled_ratio(1, s1);
      return r;
    endfunction

    function void note_triangle(tri_in_t t);
      expected_q.push_back(predict_result(t));
    endfunction

    task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      mismatches++;
      $display("mismatch %s: got %h expected %h", what, got, want);
    endtask

    task check_result(tri_res_t got);
      tri_res_t want;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", 64'(got.area), 64'd0);
        return;
      end
      want = expected_q.pop_front();
      if (got.area != want.area)
        report_mismatch("area", 64'(got.area), 64'(want.area));
      if (got.inv_00 != want.inv_00)
        report_mismatch("inv_00", 64'(got.inv_00), 64'(want.inv_00));
      if (got.inv_01 != want.inv_01)
        report_mismatch("inv_01", 64'(got.inv_01), 64'(want.inv_01));
      if (got.inv_10 != want.inv_10)
        report_mismatch("inv_10", 64'(got.inv_10), 64'(want.inv_10));
      if (got.inv_11 != want.inv_11)
        report_mismatch("inv_11", 64'(got.inv_11), 64'(want.inv_11));
      if (got.degenerate != want.degenerate)
        report_mismatch("degenerate", 64'(got.degenerate), 64'(want.degenerate));
    endtask
  endclass

  localparam int STALL_LIMIT = 5000;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     tri_valid = 1'b0;
  logic     tri_stall;
  tri_in_t  tri_data = '0;
  logic     res_valid;
  logic     res_stall = 1'b0;
  tri_res_t res_data;

  area_inverse_board board = new();
  int  idle_cycles = 0;
  bit  bursty_tx = 1'b1;
  bit  bursty_rx = 1'b1;

  triangle_rest_basis_inverse dut (
    .clk(clk), .rst(rst),
    .tri_valid(tri_valid), .tri_stall(tri_stall), .tri_data(tri_data),
    .res_valid(res_valid), .res_stall(res_stall), .res_data(res_data)
  );

  always #10 clk = ~clk;

  // mostly short gaps, a few long ones
  function automatic int gap_len(bit enable);
    int r;
    if (!enable) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // receiver back-pressure, with calm stretches
  always @(negedge clk) begin
    if ($urandom_range(0, 199) == 0) bursty_rx <= ~bursty_rx;
    res_stall <= (gap_len(bursty_rx) > 0) && ($urandom_range(0, 1) == 1);
  end

  // monitor both channels and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (tri_valid && !tri_stall) board.note_triangle(tri_data);
      if (res_valid && !res_stall) board.check_result(res_data);
      if ((tri_valid && !tri_stall) || (res_valid && !res_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("** triangle_rest_basis_inverse: FAILED **");
        $finish;
      end
    end
  end

  task automatic send_triangle(tri_in_t t);
    int gap;
    @(negedge clk);
    tri_valid <= 1'b1;
    tri_data  <= t;
    @(posedge clk);
    while (tri_stall) @(posedge clk);
    gap = gap_len(bursty_tx);
    repeat (gap) begin
      @(negedge clk);
      tri_valid <= 1'b0;
    end
  endtask

  function automatic tri_in_t make_triangle(logic [31:0] a0, a1, a2, b0, b1, b2,
                                             c0, c1, c2);
    tri_in_t t;
    t = {a0, a1, a2, b0, b1, b2, c0, c1, c2};
    return t;
  endfunction

  // coordinate drawn from one of several scales
  function automatic logic [31:0] rand_coord(int scale);
    case (scale)
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 32'h003F_FFFF)) - 32'sh0020_0000);
      2: return 32'($signed($urandom_range(0, 511)) - 256);
      default: return 32'($signed($urandom_range(0, 32'h07FF_FFFF)) - 32'sh0400_0000);
    endcase
  endfunction

  function automatic tri_in_t rand_triangle();
    tri_in_t     t;
    int          scale;
    logic [31:0] c[9];
    scale = $urandom_range(0, 3);
    foreach (c[i]) c[i] = rand_coord(scale);
    case ($urandom_range(0, 9))
      // collinear: third vertex on the line of the first edge
      0: for (int k = 0; k < 3; k++) c[6 + k] = c[k] + 2 * (c[3 + k] - c[k]);
      // repeated first vertex
      1: for (int k = 0; k < 3; k++) c[3 + k] = c[k];
      // small triangle around a random center
      2: for (int k = 0; k < 9; k++) c[k] = c[k % 3] + rand_coord(2);
      default: ;
    endcase
    t = make_triangle(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7], c[8]);
    return t;
  endfunction

  localparam logic [31:0] ONE  = 32'h0001_0000;
  localparam logic [31:0] MAXC = 32'h7FFF_FFFF;
  localparam logic [31:0] MINC = 32'h8000_0000;

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: degenerate cases, unit triangles, extremes, tiny edges
    send_triangle('0);
    send_triangle(make_triangle(0, 0, 0, 0, 0, 0, ONE, 0, 0));
    send_triangle(make_triangle(0, 0, 0, ONE, ONE, ONE, 2*ONE, 2*ONE, 2*ONE));
    send_triangle(make_triangle(0, 0, 0, ONE, 0, 0, 0, ONE, 0));
    send_triangle(make_triangle(0, 0, 0, 0, ONE, 0, 0, 0, ONE));
    send_triangle(make_triangle(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE));
    send_triangle(make_triangle(0, 0, 0, 1, 0, 0, 0, 1, 0));
    send_triangle(make_triangle(0, 0, 0, 0, 0, 1, 1, 0, 0));
    send_triangle(make_triangle(MINC, MINC, MINC, MAXC, MINC, MINC, MINC, MAXC, MAXC));
    send_triangle(make_triangle(MAXC, MAXC, MAXC, MINC, MAXC, MAXC, MAXC, MINC, MINC));
    send_triangle(make_triangle(MINC, MAXC, 0, MAXC, MINC, 0, MAXC, MAXC, MAXC));
    send_triangle(make_triangle(MAXC, 0, 0, MINC, 0, 0, 0, MAXC, 0));
    send_triangle(make_triangle(0, 0, 0, MAXC, 0, 0, MAXC, 1, 0));
    send_triangle(make_triangle(0, 0, 0, 1, 0, 0, MAXC, MAXC, 0));
    send_triangle(make_triangle(5*ONE, -3*ONE, ONE, -2*ONE, 7*ONE, 0, ONE, ONE, -4*ONE));
    send_triangle(make_triangle(0, 0, 0, 3*ONE, 0, 0, -5*ONE, 2*ONE, 0));
    send_triangle(make_triangle(MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MINC, 0, 0));
    send_triangle(make_triangle(32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA,
                                32'h1234_5678, 32'h8765_4321, 0, 1, 32'hFFFF_0000, MINC));

    // let the pipeline drain completely before random traffic
    @(negedge clk);
    tri_valid <= 1'b0;
    while (board.expected_q.size() > 0) @(posedge clk);

    // random traffic with changing burstiness
    for (int i = 0; i < 900; i++) begin
      if ($urandom_range(0, 99) == 0) bursty_tx = ~bursty_tx;
      send_triangle(rand_triangle());
    end

    @(negedge clk);
    tri_valid <= 1'b0;
    while (board.expected_q.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);

    if (board.mismatches == 0 && board.expected_q.size() == 0) begin
      $display("** triangle_rest_basis_inverse: PASSED **");
    end else begin
      $display("** triangle_rest_basis_inverse: FAILED **");
    end
    $finish;
  end

endmodule
